[hdl/rbnd_pkg.sv]
// Shared types, constants and helper functions for the RAW12 Bayer demosaic block.
package rbnd_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int COORD_W  = 12;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int PAIRS_W  = 12;
    localparam int ROWS_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LINE_W   = 2 * COLOR_W;

    // Hard limits of the counters and the line store.
    localparam int LINE_DEPTH_MAX = 2048;
    localparam int ROWS_MAX       = 4096;

    // Register reset values.
    localparam logic [PAIRS_W-1:0] PAIRS_RESET = 12'd2048;
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 13'd3072;

    // Default image limits.
    localparam int MAX_IMAGE_WIDTH_DEF  = 4096;
    localparam int MAX_IMAGE_HEIGHT_DEF = 4096;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAIRS_PER_ROW = 2'd0,
        REG_FRAME_ROWS    = 2'd1
    } cfg_index_t;

    // One odd-row block on its way to the back end.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic               last;
    } block_t;

    // Pairs per row: zero acts as one, large values saturate at the cap.
    function automatic logic [PAIRS_W-1:0] clamp_pairs(input logic [PAIRS_W-1:0] v,
                                                       input logic [PAIRS_W-1:0] cap);
        logic [PAIRS_W-1:0] r;
        begin
            r = (v == '0) ? PAIRS_W'(1) : v;
            if (r > cap) r = cap;
            return r;
        end
    endfunction

    // Frame rows: rounded down to even, at least two, saturated at the cap.
    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] v,
                                                     input logic [ROWS_W-1:0] cap);
        logic [ROWS_W-1:0] r;
        begin
            r = {v[ROWS_W-1:1], 1'b0};
            if (r < ROWS_W'(2)) r = ROWS_W'(2);
            if (r > cap) r = cap;
            return r;
        end
    endfunction

endpackage

[hdl/raw12_bayer_nearest_demosaic.sv]
// Top level of the RAW12 RGGB unpacker with nearest-neighbor demosaic.
//
// Input channel (s_*): one transaction carries one packed RAW12 group of three
// bytes, i.e. two samples of a sensor row. Output channel (m_*): one
// transaction carries one full-resolution pixel with its coordinates.
// Configuration channel (cfg_*): index 0 sets the sample pairs per row, index 1 the sensor
// rows per frame; always ready. It must be written only with no pixels outstanding, by the
// user's own care; the block itself does not enforce it.
// Even sensor rows store red and green1 per column in the line RAM and emit
// nothing. Each odd-row transaction reads its stored pair, averages the greens
// and emits four pixels, one per cycle while m_ready is high, covering its 2x2 block.
// An odd-row input passes the stage-1 registers, the block queue and the output register.
// Throughput is set by the output register: one pixel per cycle while m_ready is high.
// The front end accepts a group every cycle as long as the two-entry block
// queue has room, so input and output stall independently of each other.
//
// Synchronous active-low reset clears the counters, the queue and the output valid and
// restores the register defaults; the line RAM is not cleared, as every entry is written
// on an even row first. When m_ready is low the current pixel holds and the queue fills.
module raw12_bayer_nearest_demosaic #(
    parameter int MAX_IMAGE_WIDTH  = rbnd_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int MAX_IMAGE_HEIGHT = rbnd_pkg::MAX_IMAGE_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbnd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbnd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rbnd_pkg::BYTE_W-1:0]       s_first_byte,
    input  logic [rbnd_pkg::BYTE_W-1:0]       s_middle_byte,
    input  logic [rbnd_pkg::BYTE_W-1:0]       s_final_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rbnd_pkg::COORD_W-1:0]      m_pixel_x,
    output logic [rbnd_pkg::COORD_W-1:0]      m_pixel_y,
    output logic [rbnd_pkg::COLOR_W-1:0]      m_red,
    output logic [rbnd_pkg::COLOR_W-1:0]      m_green,
    output logic [rbnd_pkg::COLOR_W-1:0]      m_blue,
    output logic                              m_block_done,
    output logic                              m_frame_done
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_head_valid;
    rbnd_pkg::block_t q_push_data;
    rbnd_pkg::block_t q_head_data;

    // Front end: counters, unpacking and line RAM.
    rbnd_front #(
        .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
        .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_first_byte  (s_first_byte),
        .s_middle_byte (s_middle_byte),
        .s_final_byte  (s_final_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    // Decouples the front end from the four-pixel expansion.
    rbnd_queue #(
        .DEPTH (rbnd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // Back end: one pixel per cycle into the output register while m_ready allows it.
    rbnd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_head_valid),
        .head_data    (q_head_data),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_block_done (m_block_done),
        .m_frame_done (m_frame_done)
    );

endmodule

[hdl/rbnd_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module rbnd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rbnd_front.sv]
// Front end: configuration, unpacking, row and column tracking, line store access.
module rbnd_front #(
    parameter int MAX_IMAGE_WIDTH  = rbnd_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int MAX_IMAGE_HEIGHT = rbnd_pkg::MAX_IMAGE_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbnd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbnd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rbnd_pkg::BYTE_W-1:0]       s_first_byte,
    input  logic [rbnd_pkg::BYTE_W-1:0]       s_middle_byte,
    input  logic [rbnd_pkg::BYTE_W-1:0]       s_final_byte,
    input  logic                              q_full,
    output logic                              q_push,
    output rbnd_pkg::block_t                  q_data
);

    localparam int HALF_W    = MAX_IMAGE_WIDTH / 2;
    localparam int PAIRS_CAP = (HALF_W < rbnd_pkg::LINE_DEPTH_MAX) ? HALF_W
                                                                    : rbnd_pkg::LINE_DEPTH_MAX;
    localparam int EVEN_H    = MAX_IMAGE_HEIGHT - (MAX_IMAGE_HEIGHT % 2);
    localparam int ROWS_CAP0 = (EVEN_H < rbnd_pkg::ROWS_MAX) ? EVEN_H : rbnd_pkg::ROWS_MAX;
    localparam int ROWS_CAP  = (ROWS_CAP0 < 2) ? 2 : ROWS_CAP0;
    localparam int LINE_AW   = (PAIRS_CAP < 2) ? 1 : $clog2(PAIRS_CAP);
    localparam int LINE_DEPTH = 1 << LINE_AW;

    localparam logic [rbnd_pkg::PAIRS_W-1:0] PAIRS_CAP_V = rbnd_pkg::PAIRS_W'(PAIRS_CAP);
    localparam logic [rbnd_pkg::ROWS_W-1:0]  ROWS_CAP_V  = rbnd_pkg::ROWS_W'(ROWS_CAP);

    // Effective register values, clamped when written.
    logic [rbnd_pkg::PAIRS_W-1:0] pairs_reg;
    logic [rbnd_pkg::ROWS_W-1:0]  rows_reg;

    logic [rbnd_pkg::COL_W-1:0]   col_reg,  col_next;
    logic [rbnd_pkg::ROW_W-1:0]   row_reg,  row_next;

    logic                          s1_valid_reg, s1_valid_next;
    logic [rbnd_pkg::COLOR_W-1:0]  s1_left_reg;
    logic [rbnd_pkg::COLOR_W-1:0]  s1_right_reg;
    logic [rbnd_pkg::COORD_W-1:0]  s1_x0_reg;
    logic [rbnd_pkg::COORD_W-1:0]  s1_y0_reg;
    logic                          s1_last_reg;

    logic                          accept;
    logic                          odd_row;
    logic [rbnd_pkg::COLOR_W-1:0]  left;
    logic [rbnd_pkg::COLOR_W-1:0]  right;
    logic [rbnd_pkg::PAIRS_W-1:0]  col_inc;
    logic [rbnd_pkg::ROWS_W-1:0]   row_inc;
    logic                          col_wrap;
    logic                          row_wrap;
    logic                          last_block;
    logic [rbnd_pkg::LINE_W-1:0]   line_rdata;
    logic [rbnd_pkg::COLOR_W:0]    green_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pairs_reg <= rbnd_pkg::clamp_pairs(rbnd_pkg::PAIRS_RESET, PAIRS_CAP_V);
            rows_reg  <= rbnd_pkg::clamp_rows(rbnd_pkg::ROWS_RESET, ROWS_CAP_V);
        end else if (cfg_valid) begin
            unique case (rbnd_pkg::cfg_index_t'(cfg_index))
                rbnd_pkg::REG_PAIRS_PER_ROW: begin
                    pairs_reg <= rbnd_pkg::clamp_pairs(cfg_data[rbnd_pkg::PAIRS_W-1:0],
                                                       PAIRS_CAP_V);
                end
                rbnd_pkg::REG_FRAME_ROWS: begin
                    rows_reg <= rbnd_pkg::clamp_rows(cfg_data, ROWS_CAP_V);
                end
                default: begin
                end
            endcase
        end
    end

    // Unpack: the left sample is byte 0, the right sample straddles bytes 1 and 2.
    assign left  = s_first_byte;
    assign right = {s_middle_byte[3:0], s_final_byte[7:4]};

    assign s_ready = !s1_valid_reg || !q_full;
    assign accept  = s_valid && s_ready;
    assign odd_row = row_reg[0];

    assign col_inc    = {1'b0, col_reg} + rbnd_pkg::PAIRS_W'(1);
    assign row_inc    = {1'b0, row_reg} + rbnd_pkg::ROWS_W'(1);
    assign col_wrap   = (col_inc >= pairs_reg);
    assign row_wrap   = (row_inc >= rows_reg);
    assign last_block = (col_inc == pairs_reg) && (row_inc == rows_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[rbnd_pkg::ROW_W-1:0];
            end else begin
                col_next = col_inc[rbnd_pkg::COL_W-1:0];
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_valid_reg && !q_full) begin
            s1_valid_next = 1'b0;
        end
        if (accept && odd_row) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && odd_row) begin
            s1_left_reg  <= left;
            s1_right_reg <= right;
            s1_x0_reg    <= {col_reg, 1'b0};
            s1_y0_reg    <= {row_reg[rbnd_pkg::ROW_W-1:1], 1'b0};
            s1_last_reg  <= last_block;
        end
    end

    // Even rows write red and green1; odd rows read them back as stage 1 loads.
    rbnd_ram #(
        .WIDTH (rbnd_pkg::LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (accept && !odd_row),
        .waddr (col_reg[LINE_AW-1:0]),
        .wdata ({left, right}),
        .re    (accept && odd_row),
        .raddr (col_reg[LINE_AW-1:0]),
        .rdata (line_rdata)
    );

    assign green_sum = {1'b0, line_rdata[rbnd_pkg::COLOR_W-1:0]} + {1'b0, s1_left_reg};

    assign q_push       = s1_valid_reg && !q_full;
    assign q_data.red   = line_rdata[rbnd_pkg::LINE_W-1:rbnd_pkg::COLOR_W];
    assign q_data.green = green_sum[rbnd_pkg::COLOR_W:1];
    assign q_data.blue  = s1_right_reg;
    assign q_data.x0    = s1_x0_reg;
    assign q_data.y0    = s1_y0_reg;
    assign q_data.last  = s1_last_reg;

endmodule

[hdl/rbnd_queue.sv]
// Small register FIFO of classified blocks between the front and back ends.
module rbnd_queue #(
    parameter int DEPTH = rbnd_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rbnd_pkg::block_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output rbnd_pkg::block_t head_data
);

    localparam int PW = (DEPTH < 2) ? 1 : $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rbnd_pkg::block_t entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/rbnd_back.sv]
// Back end: expands each block into its four pixels through the output register.
module rbnd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  rbnd_pkg::block_t              head_data,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rbnd_pkg::COORD_W-1:0]  m_pixel_x,
    output logic [rbnd_pkg::COORD_W-1:0]  m_pixel_y,
    output logic [rbnd_pkg::COLOR_W-1:0]  m_red,
    output logic [rbnd_pkg::COLOR_W-1:0]  m_green,
    output logic [rbnd_pkg::COLOR_W-1:0]  m_blue,
    output logic                          m_block_done,
    output logic                          m_frame_done
);

    logic [1:0]                    k_reg, k_next;
    logic                          m_valid_reg, m_valid_next;
    logic [rbnd_pkg::COORD_W-1:0]  x_reg;
    logic [rbnd_pkg::COORD_W-1:0]  y_reg;
    logic [rbnd_pkg::COLOR_W-1:0]  red_reg;
    logic [rbnd_pkg::COLOR_W-1:0]  green_reg;
    logic [rbnd_pkg::COLOR_W-1:0]  blue_reg;
    logic                          block_done_reg;
    logic                          frame_done_reg;
    logic                          load;
    logic                          fourth;

    assign load   = head_valid && (!m_valid_reg || m_ready);
    assign fourth = (k_reg == 2'd3);
    assign pop    = load && fourth;

    always_comb begin
        k_next       = load ? k_reg + 2'd1 : k_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Pixel order: top left, top right, bottom left, bottom right.
    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg          <= {head_data.x0[rbnd_pkg::COORD_W-1:1], k_reg[0]};
            y_reg          <= {head_data.y0[rbnd_pkg::COORD_W-1:1], k_reg[1]};
            red_reg        <= head_data.red;
            green_reg      <= head_data.green;
            blue_reg       <= head_data.blue;
            block_done_reg <= fourth;
            frame_done_reg <= fourth && head_data.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_x    = x_reg;
    assign m_pixel_y    = y_reg;
    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_block_done = block_done_reg;
    assign m_frame_done = frame_done_reg;

endmodule
